/* design/cpk_pkg.sv */
// shared types and constants of the curtain position key controller
// no dependencies; imported by every module of the block
package cpk_pkg;

  // key codes
  localparam logic [1:0] KEY_NONE   = 2'd0;
  localparam logic [1:0] KEY_DOWN   = 2'd1;
  localparam logic [1:0] KEY_UP     = 2'd2;
  localparam logic [1:0] KEY_TOGGLE = 2'd3;

  // remote commands
  localparam logic [7:0] CMD_NONE  = 8'd0;
  localparam logic [7:0] CMD_CLOSE = 8'd1;
  localparam logic [7:0] CMD_OPEN  = 8'd2;
  localparam logic [7:0] CMD_HALF  = 8'd3;

  // angles in degrees
  localparam logic [7:0] ANGLE_STEP = 8'd30;
  localparam logic [7:0] ANGLE_MAX  = 8'd180;
  localparam logic [7:0] ANGLE_HALF = 8'd90;

  // press counter ceiling
  localparam logic [7:0] COUNT_TOP = 8'd255;

  // configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
  localparam logic [1:0] REG_FWD_SCALE   = 2'd1;
  localparam logic [1:0] REG_REV_SCALE   = 2'd2;

  // configuration reset values
  localparam logic [7:0] LONG_PRESS_RST = 8'd25;
  localparam logic [5:0] FWD_SCALE_RST  = 6'd12;
  localparam logic [5:0] REV_SCALE_RST  = 6'd6;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } press_kind_t;

  // press event handed from the press detector to the angle unit
  typedef struct packed {
    press_kind_t kind;
    logic [1:0]  key;
  } press_t;

  // result of one tick
  typedef struct packed {
    logic [13:0] move_steps;
    logic        move_forward;
    logic        move_valid;
    logic        is_open;
    logic [7:0]  angle;
    press_kind_t press_kind;
  } result_t;

endpackage

/* design/cpk_press.sv */
// press detector: press counter and held key, tells short presses from long
// depends on cpk_pkg
module cpk_press
  import cpk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [1:0] key_code,
  input  logic [7:0] long_press_ticks,
  output press_t     press
);

  logic [7:0] counter, counter_next;
  logic [1:0] held_key, held_key_next;
  logic [7:0] count_start;
  logic [1:0] key_start;
  logic       key_on;

  always_comb begin
    key_on = (key_code != KEY_NONE);
    // press start latches the key
    if (key_on && counter == 8'd0) begin
      count_start = 8'd1;
      key_start   = key_code;
    end else begin
      count_start = counter;
      key_start   = held_key;
    end
    held_key_next = key_start;
    counter_next  = count_start;
    press.kind    = KIND_NONE;
    press.key     = key_start;
    if (key_on) begin
      if (count_start != 8'd0 && count_start <= long_press_ticks &&
          count_start != COUNT_TOP) begin
        counter_next = count_start + 8'd1;
      end
    end else if (counter != 8'd0) begin
      // release ends the press
      counter_next = 8'd0;
      if (counter < long_press_ticks) begin
        press.kind = KIND_SHORT;
      end else begin
        press.kind = KIND_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= 8'd0;
      held_key <= KEY_NONE;
    end else if (step_en) begin
      counter  <= counter_next;
      held_key <= held_key_next;
    end
  end

endmodule

/* design/cpk_angle.sv */
// angle unit: target angle, open flag and stepper move of one tick
// depends on cpk_pkg
module cpk_angle
  import cpk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  press_t     press,
  input  logic [7:0] remote_command,
  input  logic [5:0] fwd_scale,
  input  logic [5:0] rev_scale,
  output result_t    result
);

  logic [7:0] target_angle, target_next;
  logic [7:0] current_angle;
  logic       open_flag, open_next;
  logic [8:0] up_sum;
  logic [7:0] diff;
  logic [5:0] scale;
  logic       fwd;
  logic [13:0] product;

  always_comb begin
    target_next = target_angle;
    open_next   = open_flag;
    up_sum      = {1'b0, target_angle} + {1'b0, ANGLE_STEP};
    if (press.kind == KIND_SHORT) begin
      case (press.key)
        KEY_DOWN: begin
          if (target_angle == 8'd0) begin
            open_next = 1'b0;
          end else if (target_angle >= ANGLE_STEP) begin
            target_next = target_angle - ANGLE_STEP;
          end else begin
            target_next = 8'd0;
          end
        end
        KEY_UP: begin
          if (target_angle >= ANGLE_MAX) begin
            target_next = ANGLE_MAX;
            open_next   = 1'b1;
          end else if (up_sum > {1'b0, ANGLE_MAX}) begin
            target_next = ANGLE_MAX;
          end else begin
            target_next = up_sum[7:0];
          end
        end
        KEY_TOGGLE: begin
          if (open_flag) begin
            target_next = 8'd0;
            open_next   = 1'b0;
          end else begin
            target_next = ANGLE_MAX;
            open_next   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // the remote command acts after the key and wins
    case (remote_command)
      CMD_CLOSE: begin
        target_next = 8'd0;
        open_next   = 1'b0;
      end
      CMD_OPEN: begin
        target_next = ANGLE_MAX;
        open_next   = 1'b1;
      end
      CMD_HALF: target_next = ANGLE_HALF;
      default: begin
      end
    endcase
  end

  // stepper move toward the new target
  always_comb begin
    fwd = (target_next > current_angle);
    if (fwd) begin
      diff  = target_next - current_angle;
      scale = fwd_scale;
    end else begin
      diff  = current_angle - target_next;
      scale = rev_scale;
    end
    product = 14'(diff) * 14'(scale);
    result.press_kind   = press.kind;
    result.angle        = target_next;
    result.is_open      = open_next;
    result.move_valid   = (target_next != current_angle);
    result.move_forward = fwd;
    result.move_steps   = result.move_valid ? product : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle  <= 8'd0;
      current_angle <= 8'd0;
      open_flag     <= 1'b0;
    end else if (step_en) begin
      target_angle  <= target_next;
      current_angle <= target_next;
      open_flag     <= open_next;
    end
  end

endmodule

/* design/curtain_position_key_controller_unit.sv */
// top level of the curtain position key controller: stream ports, config
// registers, input and result registers; uses cpk_pkg, cpk_press, cpk_angle

// Each input item is one tick: the key held this tick and a remote command.
// It yields exactly one result item with the press that ended (none, short,
// long), the new target angle, the open flag and an optional stepper move.
// An item passes from s_tvalid to m_tvalid through the input register, then
// through the press and angle logic into the result register.
// The block takes one item per cycle as long as the result side keeps up;
// the tick state (press counter, held key, angles, open flag) is updated
// when the item moves into the result register, so each tick sees the
// state left by the one before. The move step count is one small multiply
// of the angle change by the steps-per-degree register of its direction.
// Config registers may be written at any time the block is idle:
//   index 0 long_press_ticks (reset 25), 1 forward steps per degree
//   (reset 12), 2 reverse steps per degree (reset 6); other indexes ignored.
module curtain_position_key_controller_unit
  import cpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // key_code[1:0], remote_command[9:2], zeros
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // press_kind[1:0], angle[9:2], is_open[10],
                                 // move_valid[11], move_forward[12],
                                 // move_steps[26:13], zeros
  // config writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // config registers
  logic [7:0] long_press_ticks;
  logic [5:0] fwd_scale;
  logic [5:0] rev_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RST;
      fwd_scale        <= FWD_SCALE_RST;
      rev_scale        <= REV_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        REG_FWD_SCALE:  fwd_scale        <= cfg_data[5:0];
        REG_REV_SCALE:  rev_scale        <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic       in_valid;
  logic [1:0] in_key;
  logic [7:0] in_cmd;
  logic       advance;

  // item moves on when the result register is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key <= s_tdata[1:0];
      in_cmd <= s_tdata[9:2];
    end
  end

  // tick logic
  press_t  press;
  result_t result;

  cpk_press u_press (
    .clk              (clk),
    .rst              (rst),
    .step_en          (advance),
    .key_code         (in_key),
    .long_press_ticks (long_press_ticks),
    .press            (press)
  );

  cpk_angle u_angle (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .press          (press),
    .remote_command (in_cmd),
    .fwd_scale      (fwd_scale),
    .rev_scale      (rev_scale),
    .result         (result)
  );

  // result register
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {5'd0, out_res};

  // checks
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.press_kind != 2'd3))
    else $error("press kind out of range");

  a_no_move_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.move_valid) |->
      (out_res.move_steps == 14'd0 && !out_res.move_forward))
    else $error("move fields set without a move");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.angle <= ANGLE_MAX))
    else $error("angle above limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> (in_valid && $stable(in_key)
      && $stable(in_cmd)))
    else $error("input stage lost an item while stalled");

endmodule

/* test/curtain_position_key_controller_unit_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for curtain_position_key_controller_unit: tick items in,
// one result item out per tick, each checked against a directed table value or a behavioral predictor
// depends on cpk_pkg and the block's rtl only
module curtain_position_key_controller_unit_tb;
  import cpk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int IDLE_PCT    = 15;      // chance per cycle that a side idles

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    logic [1:0] key;
    logic [7:0] cmd;
    bit         typed;
    result_t    want;
  } tick_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // key_code[1:0], remote_command[9:2], zeros
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // press_kind[1:0], angle[9:2], is_open[10],
                               // move_valid[11], move_forward[12],
                               // move_steps[26:13], zeros
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LONG_PRESS;
  logic [7:0]  cfg_data = '0;

  // predictor copy of the registers and the tick state
  logic [7:0] long_limit   = LONG_PRESS_RST;
  logic [5:0] open_scale   = FWD_SCALE_RST;
  logic [5:0] close_scale  = REV_SCALE_RST;
  logic [7:0] press_ticks  = '0;
  logic [1:0] latched_key  = KEY_NONE;
  logic [7:0] goal_angle   = '0;
  logic [7:0] shaft_angle  = '0;
  logic       curtain_open = 1'b0;

  result_t pending_results[$];   // expected result items, oldest first
  bit      steady = 1'b0;        // set: neither side idles
  int      fail_count = 0;
  int      cycle_count = 0;
  int      tick_count = 0;
  int      short_count = 0;
  int      long_count = 0;
  int      move_count = 0;
  int      setting_count = 0;

  always #5 clk = ~clk;

  curtain_position_key_controller_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one tick of the controller: press detection, then the remote command,
  // then the stepper move that brings the shaft to the new goal
  function automatic result_t advance_curtain(logic [1:0] key, logic [7:0] cmd);
    result_t     r;
    logic [31:0] steps;
    r = '0;
    r.press_kind = KIND_NONE;
    // a new press latches its key; later key changes in the press are ignored
    if (key != KEY_NONE && press_ticks == 8'd0) begin
      latched_key = key;
      press_ticks = 8'd1;
    end
    // count while held, up to one past the threshold, never past the ceiling
    if (key != KEY_NONE && press_ticks != 8'd0 && press_ticks <= long_limit &&
        press_ticks != COUNT_TOP)
      press_ticks = press_ticks + 8'd1;
    // release: below the threshold it is short and acts, otherwise long
    if (key == KEY_NONE && press_ticks != 8'd0) begin
      if (press_ticks < long_limit) begin
        r.press_kind = KIND_SHORT;
        case (latched_key)
          KEY_DOWN: begin
            // already closed: the step only clears the open flag
            if (goal_angle == 8'd0)
              curtain_open = 1'b0;
            else if (goal_angle >= ANGLE_STEP)
              goal_angle = goal_angle - ANGLE_STEP;
            else
              goal_angle = 8'd0;
          end
          KEY_UP: begin
            // already fully open: the step only sets the open flag
            if (goal_angle >= ANGLE_MAX)
              curtain_open = 1'b1;
            else if (ANGLE_MAX - goal_angle <= ANGLE_STEP)
              goal_angle = ANGLE_MAX;
            else
              goal_angle = goal_angle + ANGLE_STEP;
          end
          KEY_TOGGLE: begin
            goal_angle   = curtain_open ? 8'd0 : ANGLE_MAX;
            curtain_open = ~curtain_open;
          end
          default: ;
        endcase
      end else begin
        r.press_kind = KIND_LONG;
      end
      press_ticks = 8'd0;
    end
    // the remote acts after the keys and overrides them; half keeps the flag
    case (cmd)
      CMD_CLOSE: begin
        goal_angle   = 8'd0;
        curtain_open = 1'b0;
      end
      CMD_OPEN: begin
        goal_angle   = ANGLE_MAX;
        curtain_open = 1'b1;
      end
      CMD_HALF: goal_angle = ANGLE_HALF;
      default: ;
    endcase
    // any change of angle moves the stepper, even with a zero scale
    if (goal_angle != shaft_angle) begin
      r.move_valid = 1'b1;
      if (goal_angle > shaft_angle) begin
        r.move_forward = 1'b1;
        steps = (32'(goal_angle) - 32'(shaft_angle)) * 32'(open_scale);
      end else begin
        steps = (32'(shaft_angle) - 32'(goal_angle)) * 32'(close_scale);
      end
      r.move_steps = steps[13:0];
      shaft_angle  = goal_angle;
    end
    r.angle   = goal_angle;
    r.is_open = curtain_open;
    return r;
  endfunction

  function automatic tick_row_t with_result(logic [1:0] key, logic [7:0] cmd,
      press_kind_t kind, logic [7:0] angle, logic open, logic mv, logic fwd,
      logic [13:0] steps);
    tick_row_t row;
    row.key   = key;
    row.cmd   = cmd;
    row.typed = 1'b1;
    row.want  = '{move_steps: steps, move_forward: fwd, move_valid: mv,
                  is_open: open, angle: angle, press_kind: kind};
    return row;
  endfunction

  function automatic tick_row_t by_predictor(logic [1:0] key, logic [7:0] cmd);
    tick_row_t row;
    row       = with_result(key, cmd, KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 14'd0);
    row.typed = 1'b0;
    return row;
  endfunction

  task automatic check_result(result_t want, logic [31:0] bus);
    result_t got;
    got = bus[26:0];
    if (got.press_kind != want.press_kind) begin
      $error("press_kind: expected %0d, got %0d", want.press_kind, got.press_kind);
      fail_count++;
    end
    if (got.angle != want.angle) begin
      $error("angle: expected %0d, got %0d", want.angle, got.angle);
      fail_count++;
    end
    if (got.is_open != want.is_open) begin
      $error("is_open: expected %0d, got %0d", want.is_open, got.is_open);
      fail_count++;
    end
    if (got.move_valid != want.move_valid) begin
      $error("move_valid: expected %0d, got %0d", want.move_valid, got.move_valid);
      fail_count++;
    end
    if (got.move_forward != want.move_forward) begin
      $error("move_forward: expected %0d, got %0d", want.move_forward, got.move_forward);
      fail_count++;
    end
    if (got.move_steps != want.move_steps) begin
      $error("move_steps: expected %0d, got %0d", want.move_steps, got.move_steps);
      fail_count++;
    end
    if (bus[31:27] != 5'd0) begin
      $error("padding: expected 0, got %0h", bus[31:27]);
      fail_count++;
    end
  endtask

  // present one tick item and wait for it to be taken; entered and left at
  // a falling edge, valid stays high into the next call unless it idles
  task automatic send_tick(logic [1:0] key, logic [7:0] cmd, bit typed,
      result_t want);
    result_t model;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, cmd, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model = advance_curtain(key, cmd);
    pending_results.push_back(typed ? want : model);
    tick_count++;
    if (model.press_kind == KIND_SHORT) short_count++;
    if (model.press_kind == KIND_LONG) long_count++;
    if (model.move_valid) move_count++;
    @(negedge clk);
  endtask

  // drain: stop sending and wait for every result out of the two-stage pipe
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(logic [7:0] lim, logic [5:0] fwd, logic [5:0] rev);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= lim;
    @(negedge clk);
    cfg_index <= REG_FWD_SCALE;
    cfg_data  <= {2'b00, fwd};
    @(negedge clk);
    cfg_index <= REG_REV_SCALE;
    cfg_data  <= {2'b00, rev};
    @(negedge clk);
    cfg_we      <= 1'b0;
    long_limit  = lim;
    open_scale  = fwd;
    close_scale = rev;
    setting_count++;
    @(negedge clk);
  endtask

  // mostly clean press-and-release gestures with random keys and lengths,
  // some lone remote commands, and some raw noise on both fields
  task automatic random_gesture();
    int         roll;
    int         hold;
    int         near;
    logic [1:0] key;
    logic [7:0] cmd;
    roll = $urandom_range(99);
    if (roll < 70) begin
      key  = 2'($urandom_range(3, 1));
      near = int'(long_limit) + $urandom_range(4) - 3;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: hold = $urandom_range(3, 1);
        6, 7, 8:          hold = (long_limit <= 8'd40) ? near : $urandom_range(6, 1);
        default:          hold = $urandom_range(12, 5);
      endcase
      if (hold < 1) hold = 1;
      for (int i = 0; i < hold; i++) begin
        // now and then the key changes in mid-press or a command rides along
        cmd = ($urandom_range(9) == 0) ? 8'($urandom_range(3)) : CMD_NONE;
        if (i != 0 && $urandom_range(11) == 0)
          send_tick(2'($urandom_range(3, 1)), cmd, 1'b0, '0);
        else
          send_tick(key, cmd, 1'b0, '0);
      end
      cmd = ($urandom_range(4) == 0) ? 8'($urandom_range(3)) : CMD_NONE;
      send_tick(KEY_NONE, cmd, 1'b0, '0);
      repeat ($urandom_range(2)) send_tick(KEY_NONE, CMD_NONE, 1'b0, '0);
    end else if (roll < 85) begin
      send_tick(KEY_NONE, 8'($urandom_range(3)), 1'b0, '0);
    end else begin
      repeat ($urandom_range(4, 1))
        send_tick(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // one register setting: a hold just past the threshold (at the top
  // threshold this pins the counter at its ceiling), then random gestures
  task automatic run_phase(logic [7:0] lim, logic [5:0] fwd, logic [5:0] rev,
      int ticks);
    int         start;
    logic [1:0] key;
    load_settings(lim, fwd, rev);
    start = tick_count;
    key   = 2'($urandom_range(3, 1));
    repeat (int'(lim) + 3) send_tick(key, CMD_NONE, 1'b0, '0);
    send_tick(KEY_NONE, CMD_NONE, 1'b0, '0);
    while (tick_count - start < ticks) random_gesture();
    settle();
  endtask

  // result side: random back-pressure, changed at the falling edge
  always @(negedge clk)
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        check_result(pending_results.pop_front(), m_tdata);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    tick_row_t directed[$];

    // directed table at reset settings (threshold 25, scales 12 and 6)
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_NONE, 8'd0, 1'b0, 1'b0,
                                   1'b0, 14'd0));
    directed.push_back(with_result(KEY_UP, CMD_NONE, KIND_NONE, 8'd0, 1'b0, 1'b0,
                                   1'b0, 14'd0));
    // short up from closed: 30 degrees forward
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_SHORT, 8'd30, 1'b0, 1'b1,
                                   1'b1, 14'd360));
    directed.push_back(by_predictor(KEY_DOWN, CMD_NONE));
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_SHORT, 8'd0, 1'b0, 1'b1,
                                   1'b0, 14'd180));
    // down at the closed end: no move, flag cleared
    directed.push_back(by_predictor(KEY_DOWN, CMD_NONE));
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_SHORT, 8'd0, 1'b0, 1'b0,
                                   1'b0, 14'd0));
    // toggle from closed to fully open
    directed.push_back(by_predictor(KEY_TOGGLE, CMD_NONE));
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_SHORT, 8'd180, 1'b1, 1'b1,
                                   1'b1, 14'd2160));
    // up at the open end: no move, flag set
    directed.push_back(by_predictor(KEY_UP, CMD_NONE));
    directed.push_back(with_result(KEY_NONE, CMD_NONE, KIND_SHORT, 8'd180, 1'b1, 1'b0,
                                   1'b0, 14'd0));
    // remote commands; half leaves the open flag alone
    directed.push_back(with_result(KEY_NONE, CMD_HALF, KIND_NONE, 8'd90, 1'b1, 1'b1,
                                   1'b0, 14'd540));
    directed.push_back(with_result(KEY_NONE, CMD_CLOSE, KIND_NONE, 8'd0, 1'b0, 1'b1,
                                   1'b0, 14'd540));
    directed.push_back(with_result(KEY_NONE, CMD_OPEN, KIND_NONE, 8'd180, 1'b1, 1'b1,
                                   1'b1, 14'd2160));
    // unknown commands are ignored
    directed.push_back(with_result(KEY_NONE, 8'hFF, KIND_NONE, 8'd180, 1'b1, 1'b0,
                                   1'b0, 14'd0));
    directed.push_back(by_predictor(KEY_NONE, 8'h04));
    // key and command in one tick: the command wins
    directed.push_back(with_result(KEY_UP, CMD_CLOSE, KIND_NONE, 8'd0, 1'b0, 1'b1,
                                   1'b0, 14'd1080));
    directed.push_back(by_predictor(KEY_NONE, CMD_HALF));
    // key change in mid-press keeps the first key
    directed.push_back(by_predictor(KEY_DOWN, CMD_NONE));
    directed.push_back(by_predictor(KEY_TOGGLE, CMD_NONE));
    directed.push_back(by_predictor(KEY_NONE, CMD_NONE));
    directed.push_back(by_predictor(KEY_TOGGLE, 8'hAA));
    directed.push_back(by_predictor(KEY_NONE, 8'h55));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_tick(directed[i].key, directed[i].cmd, directed[i].typed, directed[i].want);
    settle();

    // threshold 2 with the largest scales
    run_phase(8'd2, 6'd63, 6'd63, 150);
    // top threshold and zero scales, with no idling on either side
    steady = 1'b1;
    run_phase(8'd255, 6'd0, 6'd0, 350);
    steady = 1'b0;
    // thresholds below the legal range: every press ends long
    run_phase(8'd1, 6'd1, 6'd63, 100);
    run_phase(8'd0, 6'd63, 6'd1, 80);
    run_phase(8'($urandom_range(40, 2)), 6'($urandom_range(63)), 6'($urandom_range(63)),
              200);
    // back to the reset values
    run_phase(LONG_PRESS_RST, FWD_SCALE_RST, REV_SCALE_RST, 150);

    repeat (10) @(posedge clk);
    $display("covered %0d ticks under %0d register settings after the reset one",
             tick_count, setting_count);
    $display("saw %0d short and %0d long presses and %0d stepper moves, %0d mismatches",
             short_count, long_count, move_count, fail_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
